// ----- hw/rtl/rcd_pkg.sv -----
package rcd_pkg;

	typedef enum logic [1:0] {
		PH_CMD   = 2'd0,
		PH_RELAY = 2'd1,
		PH_SUM   = 2'd2
	} phase_t;

	localparam logic [7:0] CMD_GET   = 8'hA0;
	localparam logic [7:0] CMD_SET   = 8'hB0;
	localparam logic [7:0] CMD_RESET = 8'hC0;

	localparam logic RESP_NACK = 1'b0;
	localparam logic RESP_ACK  = 1'b1;

	localparam int unsigned RELAYS = 4;

	typedef struct packed {
		phase_t              phase;
		logic [7:0]          cmd;
		logic [1:0]          relay;
		logic [RELAYS-1:0]   set_drive;
		logic [RELAYS-1:0]   reset_drive;
	} dec_state_t;

	typedef struct packed {
		logic                emit;
		logic                resp;
		logic [RELAYS-1:0]   set_lines;
		logic [RELAYS-1:0]   reset_lines;
	} dec_result_t;

endpackage

// ----- hw/rtl/rcd_decode.sv -----
module rcd_decode import rcd_pkg::*; (
	input  dec_state_t             cur,
	input  logic [7:0]             rx_byte,
	input  logic [RELAYS-1:0]      relay_feedback,
	output dec_state_t             nxt,
	output dec_result_t            res
);

	logic              is_cmd;
	logic              is_relay;
	logic              sum_ok;
	logic [RELAYS-1:0] sel;

	assign is_cmd   = (rx_byte == CMD_GET) || (rx_byte == CMD_SET) || (rx_byte == CMD_RESET);
	assign is_relay = (rx_byte[7:2] == 6'd0);
	// A valid command plus a relay number tops out at 0xC3, so eight bits never wrap.
	assign sum_ok   = (rx_byte == (cur.cmd + {6'd0, cur.relay}));
	assign sel      = RELAYS'(1) << cur.relay;

	// Next state.
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_RELAY: begin
				if (is_relay) begin
					nxt.relay = rx_byte[1:0];
					nxt.phase = PH_SUM;
				end else begin
					nxt.cmd   = 8'd0;
					nxt.phase = PH_CMD;
				end
			end
			PH_SUM: begin
				nxt.phase = PH_CMD;
				if (sum_ok) begin
					unique case (cur.cmd)
						CMD_SET: begin
							nxt.set_drive   = cur.set_drive | sel;
							nxt.reset_drive = cur.reset_drive & ~sel;
						end
						CMD_RESET: begin
							nxt.set_drive   = cur.set_drive & ~sel;
							nxt.reset_drive = cur.reset_drive | sel;
						end
						default: ;
					endcase
				end
			end
			default: begin
				if (is_cmd) begin
					nxt.cmd   = rx_byte;
					nxt.phase = PH_RELAY;
				end else begin
					nxt.phase = PH_CMD;
				end
			end
		endcase
	end

	// Result beat.
	always_comb begin
		res.emit        = 1'b0;
		res.resp        = RESP_NACK;
		res.set_lines   = nxt.set_drive;
		res.reset_lines = nxt.reset_drive;
		unique case (cur.phase)
			PH_RELAY: begin
				res.emit = !is_relay;
			end
			PH_SUM: begin
				res.emit = 1'b1;
				if (sum_ok) begin
					unique case (cur.cmd)
						CMD_GET:   res.resp = |(relay_feedback & sel);
						CMD_SET:   res.resp = RESP_ACK;
						CMD_RESET: res.resp = RESP_ACK;
						default:   res.resp = RESP_NACK;
					endcase
				end
			end
			default: begin
				res.emit = !is_cmd;
			end
		endcase
	end

endmodule

// ----- hw/rtl/relay_command_decoder_core.sv -----
// Relay command decoder: takes one received byte per beat and assembles three-byte commands
// (command 0xA0 get, 0xB0 set, 0xC0 reset; relay number 0 to 3; checksum equal to the sum of
// the first two). The command and relay bytes give no response; a bad byte or a wrong
// checksum answers NACK (0), a good set or reset answers ACK (1) and a good get answers the
// chosen relay's feedback bit. Every response also carries the current set and reset drive
// lines. A byte is decoded in the cycle it is accepted and its response appears on the
// output register in the next cycle, so the block takes one byte per cycle; the only thing
// that holds input back is a full output register that the sink is not taking.
module relay_command_decoder_core import rcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] rx_byte, [11:8] relay_feedback, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [0] response_byte, [4:1] set_lines, [8:5] reset_lines,
	                              // [15:9] zero
);

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        out_valid_s1;
	logic        out_resp_s1;
	logic [RELAYS-1:0] out_set_s1;
	logic [RELAYS-1:0] out_rst_s1;
	logic        accept;

	assign s_tready = !out_valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	rcd_decode u_decode (
		.cur            (state_q),
		.rx_byte        (s_tdata[7:0]),
		.relay_feedback (s_tdata[11:8]),
		.nxt            (state_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_CMD;
			state_q.cmd         <= 8'd0;
			state_q.relay       <= 2'd0;
			state_q.set_drive   <= '0;
			state_q.reset_drive <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept && res.emit) begin
			out_valid_s1 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.emit) begin
			out_resp_s1 <= res.resp;
			out_set_s1  <= res.set_lines;
			out_rst_s1  <= res.reset_lines;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tdata  = {7'd0, out_rst_s1, out_set_s1, out_resp_s1};

endmodule

// ----- hw/rtl/rcd_checker.sv -----
module rcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled response beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response beat changed while stalled");

	// A relay is never driven to set and reset at the same time.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:1] & m_tdata[8:5]) == 4'd0)
		else $error("set and reset lines overlap");

	// With the output register full and stalled, no byte is taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while response stalled");

	// A byte from 0x04 to 0x3F is no command, relay number or checksum in any phase.
	a_nack: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[7:6] == 2'b00 && s_tdata[5:2] != 4'd0
		|=> m_tvalid && !m_tdata[0])
		else $error("junk byte did not give NACK");

endmodule

bind relay_command_decoder_core rcd_checker u_rcd_checker (.*);

// ----- dv/relay_command_decoder_core_test.sv -----
import rcd_pkg::*;

class relay_reply_board;
	typedef struct packed {
		logic              resp;
		logic [RELAYS-1:0] set_lines;
		logic [RELAYS-1:0] reset_lines;
	} reply_t;

	phase_t            phase;
	logic [7:0]        cmd;
	logic [1:0]        relay;
	logic [RELAYS-1:0] set_drive;
	logic [RELAYS-1:0] reset_drive;
	reply_t            pending_replies[$];
	int                failures;
	int                bytes_seen;
	int                replies_checked;
	int                commands_done;
	int                rejected;

	function new();
		phase = PH_CMD;
		cmd = '0;
		relay = '0;
		set_drive = '0;
		reset_drive = '0;
		failures = 0;
		bytes_seen = 0;
		replies_checked = 0;
		commands_done = 0;
		rejected = 0;
	endfunction

	function void push_reply(logic resp);
		reply_t r;
		r.resp = resp;
		r.set_lines = set_drive;
		r.reset_lines = reset_drive;
		pending_replies.push_back(r);
	endfunction

	function void note_byte(logic [7:0] rx, logic [RELAYS-1:0] fb);
		logic [RELAYS-1:0] relay_mask;
		bytes_seen++;
		case (phase)
			PH_RELAY: begin
				if (int'(rx) < RELAYS) begin
					relay = rx[1:0];
					phase = PH_SUM;
				end else begin
					cmd = '0;
					phase = PH_CMD;
					rejected++;
					push_reply(RESP_NACK);
				end
			end
			PH_SUM: begin
				phase = PH_CMD;
				relay_mask = RELAYS'(1) << relay;
				// The checksum is compared without wrapping to eight bits.
				if (int'(rx) != int'(cmd) + int'(relay)) begin
					rejected++;
					push_reply(RESP_NACK);
				end else begin
					commands_done++;
					case (cmd)
						CMD_GET: push_reply(fb[relay]);
						CMD_SET: begin
							reset_drive &= ~relay_mask;
							set_drive |= relay_mask;
							push_reply(RESP_ACK);
						end
						CMD_RESET: begin
							set_drive &= ~relay_mask;
							reset_drive |= relay_mask;
							push_reply(RESP_ACK);
						end
						default: push_reply(RESP_NACK);
					endcase
				end
			end
			default: begin
				if (rx == CMD_GET || rx == CMD_SET || rx == CMD_RESET) begin
					cmd = rx;
					phase = PH_RELAY;
				end else begin
					phase = PH_CMD;
					rejected++;
					push_reply(RESP_NACK);
				end
			end
		endcase
	endfunction

	function void check_reply(logic [15:0] data);
		reply_t exp;
		if (pending_replies.size() == 0) begin
			$error("response beat %h arrived with nothing expected", data);
			failures++;
			return;
		end
		exp = pending_replies.pop_front();
		replies_checked++;
		if (data[0] !== exp.resp) begin
			$error("response_byte: expected %0d, got %0d", exp.resp, data[0]);
			failures++;
		end
		if (data[4:1] !== exp.set_lines) begin
			$error("set_lines: expected %b, got %b", exp.set_lines, data[4:1]);
			failures++;
		end
		if (data[8:5] !== exp.reset_lines) begin
			$error("reset_lines: expected %b, got %b", exp.reset_lines, data[8:5]);
			failures++;
		end
	endfunction
endclass

module relay_command_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BYTES = 500;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	relay_reply_board board = new();

	int burst_left = 1;
	int idle_cycles = 0;
	int ready_mode = 0;
	int ready_cycle = 0;

	relay_command_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sends one byte, then decides whether the current burst is over and, if so, may idle.
	task automatic send_byte(logic [7:0] rx, logic [3:0] fb);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, fb, rx};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_byte(rx, fb);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 12);
		end
	endtask

	task automatic send_command(logic [7:0] cmd, logic [7:0] relay, logic [7:0] sum,
	                            logic [3:0] fb);
		send_byte(cmd, fb);
		send_byte(relay, fb);
		send_byte(sum, fb);
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (board.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 2))
			0: return CMD_GET;
			1: return CMD_SET;
			default: return CMD_RESET;
		endcase
	endfunction

	// Sink side: checks on the edge, then picks the next ready value from a mode that
	// is re-drawn at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_reply(m_tdata);
		ready_cycle++;
		if (ready_cycle % 48 == 0)
			ready_mode = $urandom_range(0, 3);
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= (ready_cycle % 3 == 0);
			2: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [7:0] cmd;
		logic [7:0] relay;
		int         sent;
		int         kind;
		bit         paused;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: rejected bytes, every command, both feedback levels, bad
		// relay numbers, checksum mismatches and a command byte where a relay is due.
		send_byte(8'h00, 4'h0);
		send_byte(8'hFF, 4'hF);
		send_command(CMD_SET, 8'h00, CMD_SET + 8'h00, 4'h5);
		send_command(CMD_RESET, 8'h03, CMD_RESET + 8'h03, 4'hA);
		send_command(CMD_GET, 8'h03, CMD_GET + 8'h03, 4'b1000);
		send_command(CMD_GET, 8'h03, CMD_GET + 8'h03, 4'b0111);
		send_command(CMD_GET, 8'h00, CMD_GET + 8'h00, 4'b0001);
		send_byte(CMD_SET, 4'h0);
		send_byte(8'h04, 4'h0);
		send_byte(CMD_GET, 4'hF);
		send_byte(8'hFF, 4'hF);
		send_command(CMD_SET, 8'h02, CMD_SET + 8'h03, 4'h3);
		send_command(CMD_RESET, 8'h01, 8'h00, 4'hC);
		send_byte(CMD_GET, 4'h6);
		send_byte(CMD_GET, 4'h9);
		send_command(CMD_SET, 8'h01, CMD_SET + 8'h01, 4'h0);
		send_command(CMD_RESET, 8'h01, CMD_RESET + 8'h01, 4'hF);

		// Random part: mostly well-formed commands, the rest broken ones and noise.
		sent = 0;
		paused = 0;
		while (sent < RANDOM_BYTES) begin
			if (!paused && sent >= RANDOM_BYTES / 2) begin
				drain_replies();
				@(posedge clk);
				paused = 1;
			end
			kind = $urandom_range(0, 99);
			cmd = pick_command();
			relay = 8'($urandom_range(0, RELAYS - 1));
			if (kind < 70) begin
				send_command(cmd, relay, cmd + relay, 4'($urandom_range(0, 15)));
				sent += 3;
			end else if (kind < 80) begin
				send_command(cmd, relay, cmd + relay + 8'($urandom_range(1, 255)),
				             4'($urandom_range(0, 15)));
				sent += 3;
			end else if (kind < 88) begin
				send_byte(cmd, 4'($urandom_range(0, 15)));
				send_byte(8'($urandom_range(RELAYS, 255)), 4'($urandom_range(0, 15)));
				sent += 2;
			end else begin
				send_byte(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
				sent += 1;
			end
		end

		drain_replies();
		repeat (4) @(posedge clk);

		$display("Covered %0d bytes: %0d commands carried out, %0d rejected,",
		         board.bytes_seen, board.commands_done, board.rejected);
		$display("%0d responses checked.", board.replies_checked);
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/rcd_pkg.sv
hw/rtl/rcd_decode.sv
hw/rtl/relay_command_decoder_core.sv
hw/rtl/rcd_checker.sv
dv/relay_command_decoder_core_test.sv
